// ===== rtl/omcd_pkg.sv =====
// omcd_pkg: shared constants, types and register codes of the object motion change detector
// no dependencies; used by the core top level and its testbench
package omcd_pkg;

	localparam int OBJECT_COUNT = 16;
	localparam int OBJ_AW       = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;

	localparam int IDX_W    = 4;
	localparam int POS_W    = 16;
	localparam int ORIENT_W = 17;
	localparam int DIST2_W  = 34;
	localparam int ADELTA_W = 18;
	localparam int HDELTA_W = 17;

	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	localparam logic [15:0] DIST_THR_RESET     = 16'd100;
	localparam logic [15:0] HEIGHT_THR_RESET   = 16'd70;
	localparam logic [16:0] ANGLE_THR_RESET    = 17'd6000;
	localparam logic [15:0] HEIGHT_NOISE_RESET = 16'd0;
	localparam logic [31:0] DIST_THR_SQ_RESET  = 32'd10000;

	typedef enum logic [1:0] {
		REG_DIST_THR     = 2'd0,
		REG_HEIGHT_THR   = 2'd1,
		REG_ANGLE_THR    = 2'd2,
		REG_HEIGHT_NOISE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0]    x;
		logic signed [POS_W-1:0]    y;
		logic signed [POS_W-1:0]    z;
		logic signed [ORIENT_W-1:0] o;
	} pose_t;

	typedef struct packed {
		pose_t                   pose;
		logic signed [POS_W-1:0] prev_z;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/omcd_ram.sv =====
// omcd_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
module omcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/object_motion_change_detector_core.sv =====
// object_motion_change_detector_core: per-object pose change detector, top level
// depends on omcd_pkg and omcd_ram (per-object pose and previous height store)
//
// channel   direction  handshake                  payload
// apb cfg   in/out     psel penable pwrite pready paddr pwdata prdata
// sample    in         in_valid / in_stall        object_index pos_x pos_y pos_z orientation
// result    out        out_valid / out_stall      visible position_changed distance_squared
//                                                 angle_changed angle_delta height_changed
//                                                 height_delta
//
// one transaction per cycle sustained while out_stall is low; each sample passes the ram read
// stage, then the difference, square and sum/compare output registers
// reset loads the config register defaults and clears the per-object seen / visible flags;
// ram contents need no clearing since they are read only behind those flags
// out_stall backs up through the four stages; in_stall rises only when all are full
module object_motion_change_detector_core (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [omcd_pkg::CFG_AW-1:0]          paddr,
	input  logic [omcd_pkg::CFG_DW-1:0]          pwdata,
	output logic [omcd_pkg::CFG_DW-1:0]          prdata,
	output logic                                 pready,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [omcd_pkg::IDX_W-1:0]           object_index,
	input  logic signed [omcd_pkg::POS_W-1:0]    pos_x,
	input  logic signed [omcd_pkg::POS_W-1:0]    pos_y,
	input  logic signed [omcd_pkg::POS_W-1:0]    pos_z,
	input  logic signed [omcd_pkg::ORIENT_W-1:0] orientation,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 visible,
	output logic                                 position_changed,
	output logic [omcd_pkg::DIST2_W-1:0]         distance_squared,
	output logic                                 angle_changed,
	output logic signed [omcd_pkg::ADELTA_W-1:0] angle_delta,
	output logic                                 height_changed,
	output logic [omcd_pkg::HDELTA_W-1:0]        height_delta
);

	localparam int AW = omcd_pkg::OBJ_AW;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [15:0]          dist_thr_q;
	logic [15:0]          height_thr_q;
	logic [16:0]          angle_thr_q;
	logic [15:0]          height_noise_q;
	logic [31:0]          dist_thr_sq_q;
	logic                 cfg_wr;
	omcd_pkg::reg_idx_t   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = omcd_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_thr_q     <= omcd_pkg::DIST_THR_RESET;
			height_thr_q   <= omcd_pkg::HEIGHT_THR_RESET;
			angle_thr_q    <= omcd_pkg::ANGLE_THR_RESET;
			height_noise_q <= omcd_pkg::HEIGHT_NOISE_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				omcd_pkg::REG_DIST_THR:     dist_thr_q     <= pwdata[15:0];
				omcd_pkg::REG_HEIGHT_THR:   height_thr_q   <= pwdata[15:0];
				omcd_pkg::REG_ANGLE_THR:    angle_thr_q    <= pwdata[16:0];
				omcd_pkg::REG_HEIGHT_NOISE: height_noise_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// squared threshold follows the register in the next cycle, before any sample accepted
	// since the write reaches the compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_thr_sq_q <= omcd_pkg::DIST_THR_SQ_RESET;
		end else begin
			dist_thr_sq_q <= dist_thr_q * dist_thr_q;
		end
	end

	always_comb begin
		unique case (cfg_idx)
			omcd_pkg::REG_DIST_THR:     prdata = 32'(dist_thr_q);
			omcd_pkg::REG_HEIGHT_THR:   prdata = 32'(height_thr_q);
			omcd_pkg::REG_ANGLE_THR:    prdata = 32'(angle_thr_q);
			omcd_pkg::REG_HEIGHT_NOISE: prdata = 32'(height_noise_q);
			default:                    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// pipeline flow control: each stage loads when empty or moving on
	// ------------------------------------------------------------------
	logic v1_s1, v2_s2, v3_s3, out_valid_q;
	logic en1, en2, en3, en_o;
	logic accept;

	assign en_o     = !out_valid_q || !out_stall;
	assign en3      = !v3_s3 || en_o;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_stall = !en1;
	assign accept   = in_valid && en1;

	// ------------------------------------------------------------------
	// stage 1: sample registered while the ram reads its entry
	// ------------------------------------------------------------------
	logic [omcd_pkg::IDX_W-1:0]           idx_s1;
	logic signed [omcd_pkg::POS_W-1:0]    x_s1, y_s1, z_s1;
	logic signed [omcd_pkg::ORIENT_W-1:0] o_s1;
	logic                                 inr_s1;
	logic                                 fwd_hit_s1;
	omcd_pkg::entry_t                     fwd_s1;

	logic                                 wr_en;
	logic [AW-1:0]                        wr_addr;
	omcd_pkg::entry_t                     wr_entry;
	logic [omcd_pkg::ENTRY_W-1:0]         rd_raw;
	logic [AW-1:0]                        rd_addr;

	assign rd_addr = AW'(object_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1     <= object_index;
			x_s1       <= pos_x;
			y_s1       <= pos_y;
			z_s1       <= pos_z;
			o_s1       <= orientation;
			inr_s1     <= int'(object_index) < omcd_pkg::OBJECT_COUNT;
			// the entry may be written back at the very edge it is read
			fwd_hit_s1 <= wr_en && (wr_addr == rd_addr);
			fwd_s1     <= wr_entry;
		end
	end

	omcd_ram #(
		.WIDTH(omcd_pkg::ENTRY_W),
		.DEPTH(omcd_pkg::OBJECT_COUNT)
	) u_state_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// per-object flags live in flops so reset clears them at once
	logic [omcd_pkg::OBJECT_COUNT-1:0] seen_q;
	logic [omcd_pkg::OBJECT_COUNT-1:0] has_vis_q;

	omcd_pkg::entry_t                     ent_s1;
	logic                                 vis_s1;
	logic                                 seen_s1, has_vis_s1;
	logic                                 use_pose_s1, use_h_s1;
	logic signed [omcd_pkg::POS_W:0]      dx_s1, dy_s1, dz_s1, dh_s1;
	logic signed [omcd_pkg::ADELTA_W-1:0] da_s1;
	logic [15:0]                          adx_s1, ady_s1, adz_s1, adh_s1;
	logic [16:0]                          ada_s1;
	logic [16:0]                          hd_s1;

	assign wr_addr = AW'(idx_s1);

	always_comb begin
		ent_s1      = fwd_hit_s1 ? fwd_s1 : omcd_pkg::entry_t'(rd_raw);
		vis_s1      = (x_s1 != '0) || (y_s1 != '0) || (z_s1 != '0) || (o_s1 != '0);
		seen_s1     = seen_q[wr_addr];
		has_vis_s1  = has_vis_q[wr_addr];
		use_h_s1    = inr_s1 && seen_s1;
		use_pose_s1 = use_h_s1 && has_vis_s1 && vis_s1;

		dx_s1  = {x_s1[15], x_s1} - {ent_s1.pose.x[15], ent_s1.pose.x};
		dy_s1  = {y_s1[15], y_s1} - {ent_s1.pose.y[15], ent_s1.pose.y};
		dz_s1  = {z_s1[15], z_s1} - {ent_s1.pose.z[15], ent_s1.pose.z};
		dh_s1  = {z_s1[15], z_s1} - {ent_s1.prev_z[15], ent_s1.prev_z};
		da_s1  = {o_s1[16], o_s1} - {ent_s1.pose.o[16], ent_s1.pose.o};

		adx_s1 = dx_s1[16] ? 16'(-dx_s1) : dx_s1[15:0];
		ady_s1 = dy_s1[16] ? 16'(-dy_s1) : dy_s1[15:0];
		adz_s1 = dz_s1[16] ? 16'(-dz_s1) : dz_s1[15:0];
		adh_s1 = dh_s1[16] ? 16'(-dh_s1) : dh_s1[15:0];
		ada_s1 = da_s1[17] ? 17'(-da_s1) : da_s1[16:0];

		// cannot exceed 17 bits, so no saturation is needed
		hd_s1  = {1'b0, adh_s1} + {1'b0, height_noise_q};

		// write-back: pose only moves on a visible sample, height always
		wr_en           = v1_s1 && en2 && inr_s1;
		wr_entry.pose   = vis_s1 ? omcd_pkg::pose_t'{x: x_s1, y: y_s1, z: z_s1, o: o_s1}
		                         : ent_s1.pose;
		wr_entry.prev_z = z_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			has_vis_q <= '0;
		end else if (wr_en) begin
			seen_q[wr_addr] <= 1'b1;
			if (vis_s1) begin
				has_vis_q[wr_addr] <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 2: absolute differences
	// ------------------------------------------------------------------
	logic                                 vis_s2, use_pose_s2, use_h_s2;
	logic [15:0]                          adx_s2, ady_s2, adz_s2;
	logic signed [omcd_pkg::ADELTA_W-1:0] da_s2;
	logic [16:0]                          ada_s2;
	logic [16:0]                          hd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			vis_s2      <= vis_s1;
			use_pose_s2 <= use_pose_s1;
			use_h_s2    <= use_h_s1;
			adx_s2      <= adx_s1;
			ady_s2      <= ady_s1;
			adz_s2      <= adz_s1;
			da_s2       <= da_s1;
			ada_s2      <= ada_s1;
			hd_s2       <= hd_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: squares and the angle / height compares
	// ------------------------------------------------------------------
	logic                                 vis_s3, use_pose_s3;
	logic [31:0]                          sqx_s3, sqy_s3, sqz_s3;
	logic                                 angle_chg_s3, height_chg_s3;
	logic signed [omcd_pkg::ADELTA_W-1:0] da_s3;
	logic [16:0]                          hd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v2_s2) begin
			vis_s3        <= vis_s2;
			use_pose_s3   <= use_pose_s2;
			sqx_s3        <= adx_s2 * adx_s2;
			sqy_s3        <= ady_s2 * ady_s2;
			sqz_s3        <= adz_s2 * adz_s2;
			angle_chg_s3  <= use_pose_s2 && (ada_s2 >= angle_thr_q);
			da_s3         <= use_pose_s2 ? da_s2 : '0;
			height_chg_s3 <= use_h_s2 && (hd_s2 >= {1'b0, height_thr_q});
			hd_s3         <= use_h_s2 ? hd_s2 : '0;
		end
	end

	// ------------------------------------------------------------------
	// output register: distance sum and threshold compare
	// ------------------------------------------------------------------
	logic [omcd_pkg::DIST2_W-1:0]         d2_s3;
	logic                                 visible_q, pos_chg_q, angle_chg_q, height_chg_q;
	logic [omcd_pkg::DIST2_W-1:0]         dist2_q;
	logic signed [omcd_pkg::ADELTA_W-1:0] da_q;
	logic [omcd_pkg::HDELTA_W-1:0]        hd_q;

	assign d2_s3 = 34'(sqx_s3) + 34'(sqy_s3) + 34'(sqz_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v3_s3) begin
			visible_q    <= vis_s3;
			pos_chg_q    <= use_pose_s3 && (d2_s3 >= 34'(dist_thr_sq_q));
			dist2_q      <= use_pose_s3 ? d2_s3 : '0;
			angle_chg_q  <= angle_chg_s3;
			da_q         <= da_s3;
			height_chg_q <= height_chg_s3;
			hd_q         <= hd_s3;
		end
	end

	assign out_valid        = out_valid_q;
	assign visible          = visible_q;
	assign position_changed = pos_chg_q;
	assign distance_squared = dist2_q;
	assign angle_changed    = angle_chg_q;
	assign angle_delta      = da_q;
	assign height_changed   = height_chg_q;
	assign height_delta     = hd_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_write_sets_seen: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> seen_q[$past(wr_addr)])
		else $error("write-back did not mark the object as seen");

	a_visible_implies_seen: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && has_vis_q[wr_addr] |-> seen_q[wr_addr])
		else $error("object has a stored pose but is not marked seen");

	a_invisible_no_pose: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !visible_q |-> !pos_chg_q && !angle_chg_q && (dist2_q == '0)
			&& (da_q == '0))
		else $error("invisible sample reported a pose change");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v1_s1 && v2_s2 && v3_s3 && out_valid_q)
		else $error("input stalled with an empty stage");

endmodule

// ===== test/tb_object_motion_change_detector_core.sv =====
// tb_object_motion_change_detector_core: self-checking testbench of the motion change detector
// holds its own per-object pose model; checks results against it or a typed row's result
// depends on omcd_pkg and object_motion_change_detector_core
module tb_object_motion_change_detector_core;

	localparam int CYCLE_LIMIT     = 100000;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int PHASE_COUNT     = 6;
	localparam int DRAIN_CYCLES    = 8;

	localparam int OBJECT_COUNT = omcd_pkg::OBJECT_COUNT;
	localparam int IDX_W        = omcd_pkg::IDX_W;
	localparam int POS_W        = omcd_pkg::POS_W;
	localparam int ORIENT_W     = omcd_pkg::ORIENT_W;
	localparam int DIST2_W      = omcd_pkg::DIST2_W;
	localparam int ADELTA_W     = omcd_pkg::ADELTA_W;
	localparam int HDELTA_W     = omcd_pkg::HDELTA_W;
	localparam int CFG_AW       = omcd_pkg::CFG_AW;
	localparam int CFG_DW       = omcd_pkg::CFG_DW;

	// pose extremes
	localparam logic signed [POS_W-1:0]    PMAX = 16'sh7fff;
	localparam logic signed [POS_W-1:0]    PMIN = 16'sh8000;
	localparam logic signed [ORIENT_W-1:0] OMAX = 17'sd36000;
	localparam logic signed [ORIENT_W-1:0] OMIN = -17'sd36000;

	typedef struct packed {
		logic [IDX_W-1:0]           idx;
		logic signed [POS_W-1:0]    x;
		logic signed [POS_W-1:0]    y;
		logic signed [POS_W-1:0]    z;
		logic signed [ORIENT_W-1:0] o;
	} sample_t;

	typedef struct packed {
		logic                       vis;
		logic                       pc;
		logic [DIST2_W-1:0]         d2;
		logic                       ac;
		logic signed [ADELTA_W-1:0] ad;
		logic                       hc;
		logic [HDELTA_W-1:0]        hd;
	} motion_t;

	// one row of the directed table; typed rows carry a hand-written result
	typedef struct packed {
		sample_t s;
		logic    typed;
		motion_t r;
	} dir_row_t;

	localparam motion_t FIRST_VISIBLE = '{1'b1, 1'b0, 34'd0, 1'b0, 18'sd0, 1'b0, 17'd0};
	localparam motion_t ALL_ZERO      = '{1'b0, 1'b0, 34'd0, 1'b0, 18'sd0, 1'b0, 17'd0};

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [CFG_AW-1:0]          paddr;
	logic [CFG_DW-1:0]          pwdata;
	logic [CFG_DW-1:0]          prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_stall;
	logic [IDX_W-1:0]           object_index;
	logic signed [POS_W-1:0]    pos_x;
	logic signed [POS_W-1:0]    pos_y;
	logic signed [POS_W-1:0]    pos_z;
	logic signed [ORIENT_W-1:0] orientation;
	logic                       out_valid;
	logic                       out_stall;
	logic                       visible;
	logic                       position_changed;
	logic [DIST2_W-1:0]         distance_squared;
	logic                       angle_changed;
	logic signed [ADELTA_W-1:0] angle_delta;
	logic                       height_changed;
	logic [HDELTA_W-1:0]        height_delta;

	// mirror of the config registers
	logic [15:0] dist_thr;
	logic [15:0] height_thr;
	logic [16:0] angle_thr;
	logic [15:0] height_noise;

	// mirror of the per-object store
	logic signed [POS_W-1:0]    last_x [OBJECT_COUNT];
	logic signed [POS_W-1:0]    last_y [OBJECT_COUNT];
	logic signed [POS_W-1:0]    last_z [OBJECT_COUNT];
	logic signed [ORIENT_W-1:0] last_o [OBJECT_COUNT];
	logic                       has_pose [OBJECT_COUNT];
	logic signed [POS_W-1:0]    prev_z [OBJECT_COUNT];
	logic                       seen [OBJECT_COUNT];

	motion_t  due_reports [$];
	dir_row_t stim_table [19];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       tx_idle_pct = 0;
	int       rx_idle_pct = 0;

	object_motion_change_detector_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.object_index     (object_index),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.orientation      (orientation),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.visible          (visible),
		.position_changed (position_changed),
		.distance_squared (distance_squared),
		.angle_changed    (angle_changed),
		.angle_delta      (angle_delta),
		.height_changed   (height_changed),
		.height_delta     (height_delta)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// expected result of one sample; also advances the mirrored store
	function automatic motion_t predict_motion(sample_t s);
		motion_t r;
		logic    vis;
		longint  dx, dy, dz, da, hdiff, d2, thr2;
		r = ALL_ZERO;
		vis = (s.x != 0) || (s.y != 0) || (s.z != 0) || (s.o != 0);
		r.vis = vis;
		if (seen[s.idx]) begin
			// height is always against the previous frame, visible or not
			hdiff = longint'(s.z) - longint'(prev_z[s.idx]);
			if (hdiff < 0) hdiff = -hdiff;
			hdiff = hdiff + longint'(height_noise);
			if (hdiff > 131071) hdiff = 131071;
			r.hd = hdiff[HDELTA_W-1:0];
			r.hc = (hdiff >= longint'(height_thr));
			// position and angle only against a stored visible pose
			if (vis && has_pose[s.idx]) begin
				dx = longint'(s.x) - longint'(last_x[s.idx]);
				dy = longint'(s.y) - longint'(last_y[s.idx]);
				dz = longint'(s.z) - longint'(last_z[s.idx]);
				d2 = dx * dx + dy * dy + dz * dz;
				thr2 = longint'(dist_thr) * longint'(dist_thr);
				r.d2 = d2[DIST2_W-1:0];
				r.pc = (d2 >= thr2);
				da = longint'(s.o) - longint'(last_o[s.idx]);
				r.ad = da[ADELTA_W-1:0];
				r.ac = ((da < 0) ? -da : da) >= longint'(angle_thr);
			end
		end
		if (vis) begin
			last_x[s.idx] = s.x;
			last_y[s.idx] = s.y;
			last_z[s.idx] = s.z;
			last_o[s.idx] = s.o;
			has_pose[s.idx] = 1'b1;
		end
		prev_z[s.idx] = s.z;
		seen[s.idx] = 1'b1;
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
		if (v > 32767) return PMAX;
		if (v < -32768) return PMIN;
		return v[POS_W-1:0];
	endfunction

	function automatic logic signed [ORIENT_W-1:0] clamp_orient(longint v);
		if (v > 36000) return OMAX;
		if (v < -36000) return OMIN;
		return v[ORIENT_W-1:0];
	endfunction

	// uniform offset in [-span, span]
	function automatic longint rand_offset(longint span);
		return longint'($urandom_range(32'(2 * span))) - span;
	endfunction

	// random sample: mostly a move around the object's last pose, sized near the thresholds
	task automatic make_sample(output sample_t s);
		int               kind;
		logic [IDX_W-1:0] i;
		kind = $urandom_range(99);
		// a few hot objects keep long histories, the rest spread over all indexes
		if ($urandom_range(9) < 7) i = IDX_W'($urandom_range(3));
		else i = IDX_W'($urandom_range(15));
		s.idx = i;
		if (kind < 10) begin
			// object not visible
			s.x = '0;
			s.y = '0;
			s.z = '0;
			s.o = '0;
		end else if (kind < 25) begin
			s.x = POS_W'($urandom);
			s.y = POS_W'($urandom);
			s.z = POS_W'($urandom);
			s.o = clamp_orient(longint'($urandom_range(72000)) - 36000);
		end else if (kind < 40) begin
			// same position, orientation near the angle threshold
			s.x = last_x[i];
			s.y = last_y[i];
			s.z = last_z[i];
			s.o = clamp_orient(longint'(last_o[i]) + rand_offset(longint'(angle_thr) + 4));
		end else begin
			s.x = clamp_pos(longint'(last_x[i]) + rand_offset(longint'(dist_thr) / 2 + 4));
			s.y = clamp_pos(longint'(last_y[i]) + rand_offset(longint'(dist_thr) / 2 + 4));
			s.z = clamp_pos(longint'(prev_z[i]) + rand_offset(longint'(height_thr) + 4));
			s.o = clamp_orient(longint'(last_o[i]) + rand_offset(longint'(angle_thr) + 4));
		end
	endtask

	// one sample transaction; called at a rising edge, returns at the edge that accepts it
	task automatic send_sample(sample_t s, logic typed, motion_t typed_result);
		motion_t predicted;
		motion_t due;
		// sender gaps, one nonblocking write of in_valid per edge
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		object_index <= s.idx;
		pos_x        <= s.x;
		pos_y        <= s.y;
		pos_z        <= s.z;
		orientation  <= s.o;
		do @(posedge clk); while (in_stall);
		predicted = predict_motion(s);
		due = typed ? typed_result : predicted;
		due_reports.insert(due_reports.size(), due);
	endtask

	// apb write: setup cycle, access cycle, then an idle cycle; config mirror follows
	task automatic cfg_write(omcd_pkg::reg_idx_t r, logic [CFG_DW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (r)
			omcd_pkg::REG_DIST_THR:     dist_thr = v[15:0];
			omcd_pkg::REG_HEIGHT_THR:   height_thr = v[15:0];
			omcd_pkg::REG_ANGLE_THR:    angle_thr = v[16:0];
			omcd_pkg::REG_HEIGHT_NOISE: height_noise = v[15:0];
		endcase
	endtask

	// wait until every sample in flight has produced its result
	task automatic wait_idle();
		while (due_reports.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// receiver stall, redrawn every cycle
	initial out_stall = 1'b0;
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// result transactions against the oldest pending expectation
	always @(posedge clk) begin : result_check
		motion_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				$display("%0t: result with nothing pending, visible %0d distance_squared %0d",
					$time, visible, distance_squared);
				mismatch_count++;
			end else begin
				want = due_reports.pop_front();
				check_field("visible", want.vis, visible);
				check_field("position_changed", want.pc, position_changed);
				check_field("distance_squared", want.d2, distance_squared);
				check_field("angle_changed", want.ac, angle_changed);
				check_field("angle_delta", want.ad, angle_delta);
				check_field("height_changed", want.hc, height_changed);
				check_field("height_delta", want.hd, height_delta);
			end
		end
	end

	// watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_object_motion_change_detector_core: errors");
		$finish;
	end

	initial begin : main
		sample_t s;
		int      phase;
		int      n;
		// all inputs known from time zero, reset held
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		object_index = '0;
		pos_x        = '0;
		pos_y        = '0;
		pos_z        = '0;
		orientation  = '0;
		dist_thr     = omcd_pkg::DIST_THR_RESET;
		height_thr   = omcd_pkg::HEIGHT_THR_RESET;
		angle_thr    = omcd_pkg::ANGLE_THR_RESET;
		height_noise = omcd_pkg::HEIGHT_NOISE_RESET;
		for (n = 0; n < OBJECT_COUNT; n++) begin
			last_x[n]   = '0;
			last_y[n]   = '0;
			last_z[n]   = '0;
			last_o[n]   = '0;
			has_pose[n] = 1'b0;
			prev_z[n]   = '0;
			seen[n]     = 1'b0;
		end

		// directed samples under the reset thresholds
		stim_table = '{
			// first sample at the negative extreme only records state
			'{'{4'd0, PMIN, PMIN, PMIN, OMIN}, 1'b1, FIRST_VISIBLE},
			// full swing to the positive extreme on every axis
			'{'{4'd0, PMAX, PMAX, PMAX, OMAX}, 1'b1,
				'{1'b1, 1'b1, 34'd12884508675, 1'b1, 18'sd72000, 1'b1, 17'd65535}},
			// not visible: only height, against the previous frame
			'{'{4'd0, 16'sd0, 16'sd0, 16'sd0, 17'sd0}, 1'b1,
				'{1'b0, 1'b0, 34'd0, 1'b0, 18'sd0, 1'b1, 17'd32767}},
			// back at the last visible pose, height against the hidden frame
			'{'{4'd0, PMAX, PMAX, PMAX, OMAX}, 1'b1,
				'{1'b1, 1'b0, 34'd0, 1'b0, 18'sd0, 1'b1, 17'd32767}},
			'{'{4'd0, PMIN, PMIN, PMIN, OMIN}, 1'b1,
				'{1'b1, 1'b1, 34'd12884508675, 1'b1, -18'sd72000, 1'b1, 17'd65535}},
			// first sample hidden
			'{'{4'd1, 16'sd0, 16'sd0, 16'sd0, 17'sd0}, 1'b1, ALL_ZERO},
			// seen but no visible pose stored yet
			'{'{4'd1, 16'sd10, 16'sd0, 16'sd0, 17'sd0}, 1'b1, FIRST_VISIBLE},
			// distance exactly at threshold, then just below
			'{'{4'd1, 16'sd110, 16'sd0, 16'sd0, 17'sd0}, 1'b0, ALL_ZERO},
			'{'{4'd1, 16'sd209, 16'sd0, 16'sd0, 17'sd0}, 1'b0, ALL_ZERO},
			// angle exactly at threshold, then just below going back
			'{'{4'd1, 16'sd209, 16'sd0, 16'sd0, 17'sd6000}, 1'b0, ALL_ZERO},
			'{'{4'd1, 16'sd209, 16'sd0, 16'sd0, 17'sd1}, 1'b0, ALL_ZERO},
			// height exactly at threshold, then just below
			'{'{4'd1, 16'sd209, 16'sd0, 16'sd70, 17'sd1}, 1'b0, ALL_ZERO},
			'{'{4'd1, 16'sd209, 16'sd0, 16'sd1, 17'sd1}, 1'b0, ALL_ZERO},
			// only orientation nonzero still counts as visible
			'{'{4'd2, 16'sd0, 16'sd0, 16'sd0, -17'sd1}, 1'b1, FIRST_VISIBLE},
			'{'{4'd2, 16'sd0, 16'sd0, 16'sd0, 17'sd0}, 1'b0, ALL_ZERO},
			// angle measured against the last visible pose, not the hidden frame
			'{'{4'd2, 16'sd0, 16'sd0, 16'sd0, OMAX}, 1'b0, ALL_ZERO},
			'{'{4'd15, 16'sd1, -16'sd1, PMAX, OMIN}, 1'b1, FIRST_VISIBLE},
			'{'{4'd15, PMIN, PMAX, PMIN, 17'sd35999}, 1'b0, ALL_ZERO},
			'{'{4'd7, 16'sd0, 16'sd0, 16'sd1, 17'sd0}, 1'b1, FIRST_VISIBLE}
		};

		tx_idle_pct = 8;
		rx_idle_pct = 45;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < $size(stim_table); n++) begin
			send_sample(stim_table[n].s, stim_table[n].typed, stim_table[n].r);
		end

		// random phases, each under its own register setting
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			in_valid <= 1'b0;
			wait_idle();
			case (phase)
				0: begin
					// lowest thresholds: every compared sample counts as a change
					cfg_write(omcd_pkg::REG_DIST_THR, 32'd0);
					cfg_write(omcd_pkg::REG_HEIGHT_THR, 32'd0);
					cfg_write(omcd_pkg::REG_ANGLE_THR, 32'd0);
					cfg_write(omcd_pkg::REG_HEIGHT_NOISE, 32'd0);
				end
				1: begin
					// highest thresholds and noise
					cfg_write(omcd_pkg::REG_DIST_THR, 32'd65535);
					cfg_write(omcd_pkg::REG_HEIGHT_THR, 32'd65535);
					cfg_write(omcd_pkg::REG_ANGLE_THR, 32'd72000);
					cfg_write(omcd_pkg::REG_HEIGHT_NOISE, 32'd65535);
				end
				2: begin
					cfg_write(omcd_pkg::REG_DIST_THR, $urandom_range(400));
					cfg_write(omcd_pkg::REG_HEIGHT_THR, $urandom_range(200));
					cfg_write(omcd_pkg::REG_ANGLE_THR, $urandom_range(9000));
					cfg_write(omcd_pkg::REG_HEIGHT_NOISE, $urandom_range(100));
				end
				3: begin
					cfg_write(omcd_pkg::REG_DIST_THR, 32'd1);
					cfg_write(omcd_pkg::REG_HEIGHT_THR, 32'd1);
					cfg_write(omcd_pkg::REG_ANGLE_THR, 32'd1);
					cfg_write(omcd_pkg::REG_HEIGHT_NOISE, 32'd1);
				end
				4: begin
					cfg_write(omcd_pkg::REG_DIST_THR, $urandom_range(65535));
					cfg_write(omcd_pkg::REG_HEIGHT_THR, $urandom_range(65535));
					cfg_write(omcd_pkg::REG_ANGLE_THR, $urandom_range(72000));
					cfg_write(omcd_pkg::REG_HEIGHT_NOISE, $urandom_range(65535));
				end
				default: begin
					cfg_write(omcd_pkg::REG_DIST_THR, $urandom_range(2000));
					cfg_write(omcd_pkg::REG_HEIGHT_THR, $urandom_range(1000));
					cfg_write(omcd_pkg::REG_ANGLE_THR, $urandom_range(20000));
					cfg_write(omcd_pkg::REG_HEIGHT_NOISE, $urandom_range(500));
				end
			endcase
			// receiver sparse first, then sender sparse, then full rate
			if (phase < 2) begin
				tx_idle_pct = 8;
				rx_idle_pct = 45;
			end else if (phase < 4) begin
				tx_idle_pct = 45;
				rx_idle_pct = 8;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				make_sample(s);
				send_sample(s, 1'b0, ALL_ZERO);
			end
		end

		// drain, then keep the clock running to catch stray results
		in_valid <= 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_object_motion_change_detector_core: clean");
		end else begin
			$display("tb_object_motion_change_detector_core: errors");
		end
		$finish;
	end

endmodule
